// ===== hdl/sfd_pkg.sv =====
// shared types and constants for the sensor frame deframer
package sfd_pkg;

  // position of the last header-phase byte (second length byte)
  localparam logic [3:0] HeadLastPos = 4'd8;
  // smallest legal length field (two checksum bytes, no payload)
  localparam logic [15:0] LenMin = 16'd2;

  // result kinds
  localparam logic KindPayload = 1'b0;
  localparam logic KindFrameEnd = 1'b1;

  // frame phases, one-hot
  typedef enum logic [3:0] {
    S_HEAD = 4'b0001,
    S_DATA = 4'b0010,
    S_CKH  = 4'b0100,
    S_CKL  = 4'b1000
  } state_e;

  // one result beat
  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [15:0] header_word;
    logic [31:0] device_address;
    logic [7:0]  packet_id;
    logic [15:0] frame_length;
    logic [7:0]  confirmation_code;
    logic [15:0] received_sum;
    logic        checksum_ok;
    logic        malformed;
  } res_t;

endpackage

// ===== hdl/sfd_channels_if.sv =====
// valid/ready channel interfaces for received bytes and deframer results

// received byte channel
interface sfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// deframer result channel
interface sfd_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic [15:0] header_word;
  logic [31:0] device_address;
  logic [7:0]  packet_id;
  logic [15:0] frame_length;
  logic [7:0]  confirmation_code;
  logic [15:0] received_sum;
  logic        checksum_ok;
  logic        malformed;

  modport source (
    output valid, output kind, output payload_byte, output payload_index,
    output header_word, output device_address, output packet_id,
    output frame_length, output confirmation_code, output received_sum,
    output checksum_ok, output malformed, input ready
  );
  modport sink (
    input valid, input kind, input payload_byte, input payload_index,
    input header_word, input device_address, input packet_id,
    input frame_length, input confirmation_code, input received_sum,
    input checksum_ok, input malformed, output ready
  );
endinterface

// ===== hdl/sensor_frame_deframer_checksum.sv =====
// byte-serial sensor frame deframer with 16-bit sum checksum check
//
// rx_i carries received frame bytes, one per beat: 2 header bytes, 4 address
// bytes, packet id, big-endian length L, L-2 payload bytes and a big-endian
// 16-bit checksum. res_o carries results: one beat per payload byte (kind 0,
// with its index) and one frame-end summary (kind 1) after the last checksum
// byte, or right after the length when L is below two (malformed set).
// Header, address and id bytes give no result.
// Throughput: one byte per cycle while rx_i.ready is high. The per-byte update (capture,
// 16-bit add, index compare) is done in the accepting cycle; a result is
// registered in the output register, or in the skid entry while that one waits.
// The result side is a two-entry buffer (output register plus skid entry):
// bytes keep flowing while one result waits; rx_i.ready drops only when both
// entries are full and the receiver stalls, and rises again the cycle after
// the receiver takes a beat.
// Reset clears the frame position (next byte is a header byte) and empties
// the result buffer; no bytes are taken during reset.
module sensor_frame_deframer_checksum (
  input  logic clk_i,
  input  logic rst_ni,
  sfd_rx_if.sink    rx_i,
  sfd_res_if.source res_o
);

  sfd_pkg::state_e state_q, state_d;
  logic [3:0]      hdr_cnt_q, hdr_cnt_d;
  logic [15:0]     idx_q, idx_d;

  logic [15:0] header_q;
  logic [31:0] addr_q;
  logic [7:0]  pid_q;
  logic [15:0] len_q, len_d;
  logic [15:0] sum_q;
  logic [7:0]  first_q;
  logic [7:0]  sum_hi_q;

  logic          out_valid_q, out_valid_d;
  sfd_pkg::res_t out_q, out_d;
  logic          skid_valid_q, skid_valid_d;
  sfd_pkg::res_t skid_q, skid_d;

  logic          acc;
  logic          take;
  logic          emit;
  sfd_pkg::res_t res_new;
  logic [7:0]    b;
  logic [15:0]   rsum;

  assign b    = rx_i.rx_byte;
  assign acc  = rx_i.valid & rx_i.ready;
  assign take = res_o.valid & res_o.ready;
  assign rx_i.ready = rst_ni & ~skid_valid_q;
  assign rsum = {sum_hi_q, b};
  assign len_d = {len_q[7:0], b};

  // frame sequencing and result building
  always_comb begin
    state_d   = state_q;
    hdr_cnt_d = hdr_cnt_q;
    idx_d     = idx_q;
    emit      = 1'b0;
    res_new   = '0;
    unique case (state_q)
      sfd_pkg::S_HEAD: begin
        hdr_cnt_d = hdr_cnt_q + 4'd1;
        if (hdr_cnt_q == sfd_pkg::HeadLastPos) begin
          hdr_cnt_d = '0;
          idx_d     = '0;
          if (len_d < sfd_pkg::LenMin) begin
            emit                   = 1'b1;
            res_new.kind           = sfd_pkg::KindFrameEnd;
            res_new.header_word    = header_q;
            res_new.device_address = addr_q;
            res_new.packet_id      = pid_q;
            res_new.frame_length   = len_d;
            res_new.malformed      = 1'b1;
          end else if (len_d == sfd_pkg::LenMin) begin
            state_d = sfd_pkg::S_CKH;
          end else begin
            state_d = sfd_pkg::S_DATA;
          end
        end
      end
      sfd_pkg::S_DATA: begin
        emit                  = 1'b1;
        res_new.kind          = sfd_pkg::KindPayload;
        res_new.payload_byte  = b;
        res_new.payload_index = idx_q;
        idx_d                 = idx_q + 16'd1;
        if (idx_q == len_q - 16'd3) begin
          state_d = sfd_pkg::S_CKH;
        end
      end
      sfd_pkg::S_CKH: begin
        state_d = sfd_pkg::S_CKL;
      end
      sfd_pkg::S_CKL: begin
        emit                      = 1'b1;
        res_new.kind              = sfd_pkg::KindFrameEnd;
        res_new.header_word       = header_q;
        res_new.device_address    = addr_q;
        res_new.packet_id         = pid_q;
        res_new.frame_length      = len_q;
        res_new.confirmation_code = (len_q > sfd_pkg::LenMin) ? first_q : 8'd0;
        res_new.received_sum      = rsum;
        res_new.checksum_ok       = (rsum == sum_q);
        state_d                   = sfd_pkg::S_HEAD;
      end
      default: begin
        state_d = sfd_pkg::S_HEAD;
      end
    endcase
  end

  // result buffer: output register plus one skid entry
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || take) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else if (acc && emit) begin
        out_valid_d = 1'b1;
        out_d       = res_new;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (acc && emit) begin
      skid_valid_d = 1'b1;
      skid_d       = res_new;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sfd_pkg::S_HEAD;
      hdr_cnt_q    <= '0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        state_q   <= state_d;
        hdr_cnt_q <= hdr_cnt_d;
        idx_q     <= idx_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // captured fields, running sum and result payloads
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
    if (acc) begin
      case (state_q)
        sfd_pkg::S_HEAD: begin
          if (hdr_cnt_q < 4'd2) begin
            header_q <= {header_q[7:0], b};
          end else if (hdr_cnt_q < 4'd6) begin
            addr_q <= {addr_q[23:0], b};
          end else if (hdr_cnt_q == 4'd6) begin
            pid_q <= b;
          end else if (hdr_cnt_q == 4'd7) begin
            len_q <= {8'd0, b};
          end else begin
            len_q   <= len_d;
            sum_q   <= {8'd0, pid_q} + len_d;
            first_q <= 8'd0;
          end
        end
        sfd_pkg::S_DATA: begin
          sum_q <= sum_q + {8'd0, b};
          if (idx_q == 16'd0) begin
            first_q <= b;
          end
        end
        sfd_pkg::S_CKH: begin
          sum_hi_q <= b;
        end
        default: begin
        end
      endcase
    end
  end

  // result port
  assign res_o.valid             = out_valid_q;
  assign res_o.kind              = out_q.kind;
  assign res_o.payload_byte      = out_q.payload_byte;
  assign res_o.payload_index     = out_q.payload_index;
  assign res_o.header_word       = out_q.header_word;
  assign res_o.device_address    = out_q.device_address;
  assign res_o.packet_id         = out_q.packet_id;
  assign res_o.frame_length      = out_q.frame_length;
  assign res_o.confirmation_code = out_q.confirmation_code;
  assign res_o.received_sum      = out_q.received_sum;
  assign res_o.checksum_ok       = out_q.checksum_ok;
  assign res_o.malformed         = out_q.malformed;

  // skid entry is only used behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid while output register empty");

  // a payload beat always leaves a result in the buffer
  a_payload_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && state_q == sfd_pkg::S_DATA) |=> out_valid_q)
    else $error("payload byte accepted but no result buffered");

  // header counter never runs past the second length byte
  a_hdr_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_cnt_q <= sfd_pkg::HeadLastPos)
    else $error("header byte counter out of range");

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for the sensor frame deframer with sum checksum
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // first payload byte position within a frame
  localparam logic [16:0] PayloadPos = 17'(sfd_pkg::HeadLastPos) + 17'd1;
  // receiver hold-off used to back the block up
  localparam int LongHold = 60;
  // rough number of random bytes to offer
  localparam int RandBytes = 1250;

  // one directed stimulus row: byte, whether the result is typed in, and that result
  typedef struct packed {
    logic [7:0]    rx;
    logic          typed;
    sfd_pkg::res_t want;
  } stim_row_t;

  localparam sfd_pkg::res_t NoRes = '0;

  // short frame right after reset, then an empty-payload frame with a good sum
  localparam stim_row_t DirFrames [20] = '{
    '{8'hFF, 1'b0, NoRes}, '{8'hFF, 1'b0, NoRes},
    '{8'hFF, 1'b0, NoRes}, '{8'hFF, 1'b0, NoRes},
    '{8'hFF, 1'b0, NoRes}, '{8'hFF, 1'b0, NoRes},
    '{8'hFF, 1'b0, NoRes},
    '{8'h00, 1'b0, NoRes},
    '{8'h00, 1'b1, '{sfd_pkg::KindFrameEnd, 8'h00, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF,
                    8'hFF, 16'h0000, 8'h00, 16'h0000, 1'b0, 1'b1}},
    '{8'h00, 1'b0, NoRes}, '{8'h00, 1'b0, NoRes},
    '{8'h00, 1'b0, NoRes}, '{8'h00, 1'b0, NoRes},
    '{8'h00, 1'b0, NoRes}, '{8'h00, 1'b0, NoRes},
    '{8'h00, 1'b0, NoRes},
    '{8'h00, 1'b0, NoRes}, '{8'h02, 1'b0, NoRes},
    '{8'h00, 1'b0, NoRes},
    '{8'h02, 1'b1, '{sfd_pkg::KindFrameEnd, 8'h00, 16'h0000, 16'h0000, 32'h0000_0000,
                    8'h00, 16'h0002, 8'h00, 16'h0002, 1'b1, 1'b0}}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  sfd_rx_if  rx ();
  sfd_res_if res ();

  sensor_frame_deframer_checksum i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx),
    .res_o  (res)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // deframer state as the checker sees it
  logic [16:0] frame_pos;
  logic [15:0] hdr_r;
  logic [31:0] addr_r;
  logic [7:0]  pid_r;
  logic [15:0] len_r;
  logic [15:0] sum_acc;
  logic [7:0]  first_pl;
  logic [7:0]  sum_hi;

  sfd_pkg::res_t expected_results [$];

  // side information travelling with the byte on rx
  logic          cur_typed;
  sfd_pkg::res_t cur_want;

  logic quiet;
  int   hold_reqs;
  int   mism_cnt;
  int   n_sent;
  int   n_frames;
  int   n_payload_beats;
  int   n_frame_ends;
  int   n_malformed;
  int   n_sum_fail;

  // frame-end summary from the captured fields
  function automatic sfd_pkg::res_t frame_end(logic [15:0] rsum, logic ok, logic bad);
    sfd_pkg::res_t r;
    r = '0;
    r.kind              = sfd_pkg::KindFrameEnd;
    r.header_word       = hdr_r;
    r.device_address    = addr_r;
    r.packet_id         = pid_r;
    r.frame_length      = len_r;
    r.confirmation_code = (!bad && len_r > sfd_pkg::LenMin) ? first_pl : 8'h00;
    r.received_sum      = rsum;
    r.checksum_ok       = ok;
    r.malformed         = bad;
    return r;
  endfunction

  // advance the deframer by one byte, return 1 when it yields a result
  function automatic bit deframe_byte(input logic [7:0] b, output sfd_pkg::res_t r);
    logic [16:0] dsize;
    logic [16:0] idx;
    logic [15:0] rsum;
    r = '0;
    if (frame_pos < 17'd2) begin
      hdr_r = {hdr_r[7:0], b};
      frame_pos = frame_pos + 17'd1;
      return 1'b0;
    end
    if (frame_pos < 17'd6) begin
      addr_r = {addr_r[23:0], b};
      frame_pos = frame_pos + 17'd1;
      return 1'b0;
    end
    if (frame_pos == 17'd6) begin
      pid_r = b;
      frame_pos = 17'd7;
      return 1'b0;
    end
    if (frame_pos == 17'd7) begin
      len_r = {8'h00, b};
      frame_pos = 17'd8;
      return 1'b0;
    end
    if (frame_pos == 17'(sfd_pkg::HeadLastPos)) begin
      len_r = {len_r[7:0], b};
      sum_acc = {8'h00, pid_r} + len_r;
      first_pl = 8'h00;
      if (len_r < sfd_pkg::LenMin) begin
        r = frame_end(16'h0000, 1'b0, 1'b1);
        frame_pos = '0;
        return 1'b1;
      end
      frame_pos = PayloadPos;
      return 1'b0;
    end
    // payload and checksum bytes
    dsize = {1'b0, len_r} - 17'(sfd_pkg::LenMin);
    idx = frame_pos - PayloadPos;
    if (idx < dsize) begin
      if (idx == '0) first_pl = b;
      sum_acc = sum_acc + {8'h00, b};
      r.kind = sfd_pkg::KindPayload;
      r.payload_byte = b;
      r.payload_index = idx[15:0];
      frame_pos = frame_pos + 17'd1;
      return 1'b1;
    end
    if (idx == dsize) begin
      sum_hi = b;
      frame_pos = frame_pos + 17'd1;
      return 1'b0;
    end
    rsum = {sum_hi, b};
    r = frame_end(rsum, rsum == sum_acc, 1'b0);
    frame_pos = '0;
    return 1'b1;
  endfunction

  // report one field difference
  function automatic void note_mismatch(string name, logic [31:0] want, logic [31:0] got);
    mism_cnt++;
    if (mism_cnt <= 10)
      $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, name, want, got);
  endfunction

  // mostly no gap, else short or occasional long gaps; none during quiet stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result checking and prediction, sampled at the rising edge
  always @(posedge clk_i) begin : scoreboard
    sfd_pkg::res_t got;
    sfd_pkg::res_t want;
    sfd_pkg::res_t pred;
    bit            has;
    if (res.valid === 1'b1 && res.ready === 1'b1) begin
      got = '{res.kind, res.payload_byte, res.payload_index, res.header_word,
              res.device_address, res.packet_id, res.frame_length,
              res.confirmation_code, res.received_sum, res.checksum_ok, res.malformed};
      if (expected_results.size() == 0) begin
        mism_cnt++;
        if (mism_cnt <= 10)
          $display("[%0t] result beat with nothing expected: kind %0b", $time, got.kind);
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind)
          note_mismatch("kind", 32'(want.kind), 32'(got.kind));
        if (got.payload_byte !== want.payload_byte)
          note_mismatch("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
        if (got.payload_index !== want.payload_index)
          note_mismatch("payload_index", 32'(want.payload_index), 32'(got.payload_index));
        if (got.header_word !== want.header_word)
          note_mismatch("header_word", 32'(want.header_word), 32'(got.header_word));
        if (got.device_address !== want.device_address)
          note_mismatch("device_address", want.device_address, got.device_address);
        if (got.packet_id !== want.packet_id)
          note_mismatch("packet_id", 32'(want.packet_id), 32'(got.packet_id));
        if (got.frame_length !== want.frame_length)
          note_mismatch("frame_length", 32'(want.frame_length), 32'(got.frame_length));
        if (got.confirmation_code !== want.confirmation_code)
          note_mismatch("confirmation_code", 32'(want.confirmation_code),
                        32'(got.confirmation_code));
        if (got.received_sum !== want.received_sum)
          note_mismatch("received_sum", 32'(want.received_sum), 32'(got.received_sum));
        if (got.checksum_ok !== want.checksum_ok)
          note_mismatch("checksum_ok", 32'(want.checksum_ok), 32'(got.checksum_ok));
        if (got.malformed !== want.malformed)
          note_mismatch("malformed", 32'(want.malformed), 32'(got.malformed));
        if (want.kind == sfd_pkg::KindPayload) n_payload_beats++;
        else begin
          n_frame_ends++;
          if (want.malformed) n_malformed++;
          else if (!want.checksum_ok) n_sum_fail++;
        end
      end
    end
    // accepted byte beat
    if (rst_ni && rx.valid === 1'b1 && rx.ready === 1'b1) begin
      has = deframe_byte(rx.rx_byte, pred);
      if (cur_typed) begin
        has = 1'b1;
        pred = cur_want;
      end
      if (has) expected_results.push_back(pred);
    end
  end

  // result receiver with random stalls and an occasional long hold-off
  initial begin : res_sink
    int  stall;
    int  hold;
    int  seen;
    int  r;
    logic nxt;
    stall = 0;
    hold = 0;
    seen = 0;
    res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != seen) begin
        seen = hold_reqs;
        hold = LongHold;
      end
      if (hold > 0) begin
        hold--;
        nxt = 1'b0;
      end else if (stall > 0) begin
        stall--;
        nxt = 1'b0;
      end else if (quiet) begin
        nxt = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) nxt = 1'b1;
        else if (r < 95) begin
          stall = $urandom_range(0, 2);
          nxt = 1'b0;
        end else begin
          stall = $urandom_range(8, 30);
          nxt = 1'b0;
        end
      end
      res.ready <= nxt;
    end
  end

  // offer one byte and wait for its beat, then maybe idle
  task automatic send_byte(input logic [7:0] b, input logic typed, input sfd_pkg::res_t want);
    int gap;
    @(negedge clk_i);
    rx.valid <= 1'b1;
    rx.rx_byte <= b;
    cur_typed <= typed;
    cur_want <= want;
    do @(posedge clk_i); while (rx.ready !== 1'b1);
    n_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      rx.valid <= 1'b0;
      cur_typed <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // stimulus
  initial begin : stim
    logic [7:0]  frame_bytes [$];
    logic [15:0] flen;
    logic [15:0] fsum;
    logic [7:0]  pid;
    logic [7:0]  pl;
    int          plen;
    int          r;
    rx.valid = 1'b0;
    rx.rx_byte = 8'h00;
    cur_typed = 1'b0;
    cur_want = '0;
    quiet = 1'b0;
    hold_reqs = 0;
    mism_cnt = 0;
    n_sent = 0;
    n_frames = 0;
    n_payload_beats = 0;
    n_frame_ends = 0;
    n_malformed = 0;
    n_sum_fail = 0;
    frame_pos = '0;
    hdr_r = '0;
    addr_r = '0;
    pid_r = '0;
    len_r = '0;
    sum_acc = '0;
    first_pl = '0;
    sum_hi = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed frames
    foreach (DirFrames[i]) send_byte(DirFrames[i].rx, DirFrames[i].typed, DirFrames[i].want);
    n_frames = 2;

    // random frames
    while (n_sent < RandBytes + $size(DirFrames)) begin
      // one pause until every result is back
      if (n_frames == 14) begin
        @(negedge clk_i);
        wait (expected_results.size() == 0);
        repeat (20) @(negedge clk_i);
      end
      quiet <= (n_frames % 8 == 5) || (n_frames == 6);
      r = $urandom_range(0, 99);
      if (n_frames == 6) plen = 40;
      else if (n_frames == 20) plen = 298;
      else if (r < 8) plen = -1;
      else if (r < 15) plen = 0;
      else if (r < 90) plen = $urandom_range(1, 12);
      else plen = $urandom_range(13, 48);
      if (plen < 0) flen = 16'($urandom_range(0, 1));
      else flen = 16'(plen) + sfd_pkg::LenMin;
      pid = 8'($urandom);
      frame_bytes.delete();
      repeat (6) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(pid);
      frame_bytes.push_back(flen[15:8]);
      frame_bytes.push_back(flen[7:0]);
      fsum = {8'h00, pid} + flen;
      for (int k = 0; k < plen; k++) begin
        pl = 8'($urandom);
        fsum = fsum + {8'h00, pl};
        frame_bytes.push_back(pl);
      end
      if (plen >= 0) begin
        if ($urandom_range(0, 99) >= 75) fsum = 16'($urandom);
        frame_bytes.push_back(fsum[15:8]);
        frame_bytes.push_back(fsum[7:0]);
      end
      // back the block up with a long receiver hold-off
      if (n_frames == 6) hold_reqs <= hold_reqs + 1;
      foreach (frame_bytes[k]) send_byte(frame_bytes[k], 1'b0, NoRes);
      n_frames++;
    end

    @(negedge clk_i);
    rx.valid <= 1'b0;
    cur_typed <= 1'b0;
    quiet <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (10) @(posedge clk_i);

    $display("covered %0d frames from %0d bytes: %0d payload beats, %0d frame ends",
             n_frames, n_sent, n_payload_beats, n_frame_ends);
    $display("of the frame ends %0d had a short length and %0d a bad checksum; %0d mismatches",
             n_malformed, n_sum_fail, mism_cnt);
    if (mism_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #1_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sfd_pkg.sv
hdl/sfd_channels_if.sv
hdl/sensor_frame_deframer_checksum.sv
verif/tb_top.sv
